// ===== design/wfd_pkg.sv =====
// shared types and constants of the websocket frame deframer
package wfd_pkg;

  // result event kinds
  localparam logic [2:0] EV_DATA       = 3'd0;
  localparam logic [2:0] EV_PING       = 3'd1;
  localparam logic [2:0] EV_EMPTY_DATA = 3'd2;
  localparam logic [2:0] EV_EMPTY_PING = 3'd3;
  localparam logic [2:0] EV_CLOSE      = 3'd4;
  localparam logic [2:0] EV_BAD_OP     = 3'd5;

  // input request types
  localparam logic REQ_BYTE       = 1'b0;
  localparam logic REQ_LINK_RESET = 1'b1;

  // opcodes
  localparam logic [3:0] OP_DATA_MAX = 4'd2;
  localparam logic [3:0] OP_CLOSE    = 4'd8;
  localparam logic [3:0] OP_PING     = 4'd9;
  localparam logic [3:0] OP_PONG     = 4'd10;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // extended length byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // one classified event from the parser, before unmasking
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic [3:0] opcode;
    logic       frame_end;
    logic       fin;
  } wfd_rec_t;

endpackage

// ===== design/wfd_front.sv =====
// header parser: takes received bytes and classifies them into event records
module wfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              req_type,
  input  logic [7:0]        rx_byte,
  input  logic              q_full,
  output logic              q_push,
  output wfd_pkg::wfd_rec_t q_rec
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  opcode, opcode_next;
  logic        mask, mask_next;
  logic [3:0]  hbi, hbi_next;
  logic [63:0] rem, rem_next;
  logic [31:0] key, key_next;
  logic [1:0]  kphase, kphase_next;

  logic        acc;
  logic        after_len;
  logic        hdr_done;
  logic [63:0] len_val;
  logic [63:0] rem_dec;
  logic [3:0]  hbi_dec;
  logic        last;
  logic [7:0]  kb;
  logic [2:0]  end_kind;
  logic        end_ok;
  logic        is_data;
  logic        is_ping;
  logic        is_pong;

  assign full = q_full;
  assign acc  = push & ~q_full;

  assign is_data = (opcode <= wfd_pkg::OP_DATA_MAX);
  assign is_ping = (opcode == wfd_pkg::OP_PING);
  assign is_pong = (opcode == wfd_pkg::OP_PONG);

  // single event that closes a frame with nothing else to report
  always_comb begin
    end_ok   = 1'b1;
    end_kind = wfd_pkg::EV_BAD_OP;
    if (is_data) begin
      end_kind = wfd_pkg::EV_EMPTY_DATA;
    end else if (is_ping) begin
      end_kind = wfd_pkg::EV_EMPTY_PING;
    end else if (is_pong) begin
      end_ok = 1'b0;
    end else if (opcode == wfd_pkg::OP_CLOSE) begin
      end_kind = wfd_pkg::EV_CLOSE;
    end
  end

  // key byte for the current payload index, first key byte in the top byte
  always_comb begin
    case (kphase)
      2'd0:    kb = key[31:24];
      2'd1:    kb = key[23:16];
      2'd2:    kb = key[15:8];
      default: kb = key[7:0];
    endcase
  end

  assign rem_dec = (rem != 64'd0) ? rem - 64'd1 : 64'd0;
  assign hbi_dec = (hbi != 4'd0) ? hbi - 4'd1 : 4'd0;
  assign last    = (rem_dec == 64'd0);

  always_comb begin
    phase_next  = phase;
    fin_next    = fin;
    opcode_next = opcode;
    mask_next   = mask;
    hbi_next    = hbi;
    rem_next    = rem;
    key_next    = key;
    kphase_next = kphase;
    after_len   = 1'b0;
    hdr_done    = 1'b0;
    len_val     = rem;
    q_push      = 1'b0;
    q_rec       = '0;
    q_rec.opcode = opcode;
    q_rec.fin    = fin;

    if (acc) begin
      if (req_type == wfd_pkg::REQ_LINK_RESET) begin
        phase_next  = PH_HDR0;
        fin_next    = 1'b0;
        opcode_next = 4'd0;
        mask_next   = 1'b0;
        hbi_next    = 4'd0;
        rem_next    = 64'd0;
        key_next    = 32'd0;
        kphase_next = 2'd0;
      end else begin
        case (phase)
          PH_HDR1: begin
            mask_next   = rx_byte[7];
            key_next    = 32'd0;
            kphase_next = 2'd0;
            rem_next    = 64'd0;
            if (rx_byte[6:0] == wfd_pkg::LEN_EXT16) begin
              hbi_next   = wfd_pkg::EXT16_BYTES;
              phase_next = PH_EXTLEN;
            end else if (rx_byte[6:0] == wfd_pkg::LEN_EXT64) begin
              hbi_next   = wfd_pkg::EXT64_BYTES;
              phase_next = PH_EXTLEN;
            end else begin
              rem_next  = {57'd0, rx_byte[6:0]};
              len_val   = {57'd0, rx_byte[6:0]};
              after_len = 1'b1;
            end
          end
          PH_EXTLEN: begin
            rem_next = {rem[55:0], rx_byte};
            len_val  = {rem[55:0], rx_byte};
            hbi_next = hbi_dec;
            if (hbi_dec == 4'd0) begin
              after_len = 1'b1;
            end
          end
          PH_KEY: begin
            key_next    = {key[23:0], rx_byte};
            kphase_next = kphase + 2'd1;
            if (kphase == 2'd3) begin
              hdr_done = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            kphase_next = kphase + 2'd1;
            rem_next    = rem_dec;
            if (last) begin
              phase_next = PH_HDR0;
            end
            q_rec.raw_byte  = rx_byte;
            q_rec.key_byte  = kb;
            q_rec.frame_end = last;
            if (is_data) begin
              q_push     = 1'b1;
              q_rec.kind = wfd_pkg::EV_DATA;
            end else if (is_ping) begin
              q_push     = 1'b1;
              q_rec.kind = wfd_pkg::EV_PING;
            end else if (!is_pong && last) begin
              q_push         = 1'b1;
              q_rec.kind     = end_kind;
              q_rec.raw_byte = 8'd0;
              q_rec.key_byte = 8'd0;
            end
          end
          default: begin
            fin_next    = rx_byte[7];
            opcode_next = rx_byte[3:0];
            hbi_next    = 4'd0;
            phase_next  = PH_HDR1;
          end
        endcase

        if (after_len) begin
          if (mask_next) begin
            phase_next  = PH_KEY;
            kphase_next = 2'd0;
          end else begin
            hdr_done = 1'b1;
          end
        end

        if (hdr_done) begin
          kphase_next = 2'd0;
          if (len_val == 64'd0) begin
            phase_next      = PH_HDR0;
            q_push          = end_ok;
            q_rec.kind      = end_kind;
            q_rec.frame_end = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HDR0;
      fin    <= 1'b0;
      opcode <= 4'd0;
      mask   <= 1'b0;
      hbi    <= 4'd0;
      rem    <= 64'd0;
      key    <= 32'd0;
      kphase <= 2'd0;
    end else begin
      phase  <= phase_next;
      fin    <= fin_next;
      opcode <= opcode_next;
      mask   <= mask_next;
      hbi    <= hbi_next;
      rem    <= rem_next;
      key    <= key_next;
      kphase <= kphase_next;
    end
  end

  // payload phase is only held while bytes remain
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> rem != 64'd0)
    else $error("payload phase with zero remaining length");

  // extended length phase always has bytes left to read
  a_extlen_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_EXTLEN |-> hbi != 4'd0)
    else $error("extended length phase with no bytes left");

  // a link reset brings the parser back to the first header byte
  a_link_reset: assert property (@(posedge clk) disable iff (rst)
    acc && req_type == wfd_pkg::REQ_LINK_RESET |=> phase == PH_HDR0 && rem == 64'd0)
    else $error("link reset did not clear the parser");

endmodule

// ===== design/wfd_queue.sv =====
// short event queue between the parser and the result side
module wfd_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wfd_pkg::wfd_rec_t wr_rec,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output wfd_pkg::wfd_rec_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wfd_pkg::wfd_rec_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  // a lone transfer in moves the fill count up by exactly one
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + CW'(1))
    else $error("queue count did not follow a transfer in");

endmodule

// ===== design/wfd_back.sv =====
// result formatting: unmasks payload bytes and builds the result fields
module wfd_back (
  input  wfd_pkg::wfd_rec_t rec,
  output logic [2:0]        event_kind,
  output logic [7:0]        payload_byte,
  output logic [3:0]        frame_opcode,
  output logic              frame_end,
  output logic              message_end
);

  logic has_byte;

  assign has_byte     = (rec.kind == wfd_pkg::EV_DATA) || (rec.kind == wfd_pkg::EV_PING);
  assign event_kind   = rec.kind;
  assign payload_byte = has_byte ? (rec.raw_byte ^ rec.key_byte) : 8'd0;
  assign frame_opcode = rec.opcode;
  assign frame_end    = rec.frame_end;
  assign message_end  = rec.frame_end & rec.fin;

endmodule

// ===== design/websocket_frame_deframer_unit.sv =====
// top level of the websocket frame deframer
//
// input side: push / full. each transfer carries req_type and rx_byte; a
// received byte (req_type 0) advances the frame parser, a link reset
// (req_type 1) returns it to the first header byte and gives no result.
// result side: empty / pop. while empty is low the oldest event sits on
// event_kind, payload_byte, frame_opcode, frame_end and message_end.
// payload bytes of data and ping frames come out unmasked, one per input
// byte; close, bad opcode and empty frames other than pong give a single closing event.
// throughput: one input byte per clock while full is low; the parser step
// (64-bit length decrement and compare) is combinational. a result is
// written into the event queue as its byte is transferred in and reaches
// the outputs in the next cycle if no older event is still queued.
// an event queue of QUEUE_DEPTH entries sits between the parser and the
// outputs; when the receiver stops popping it fills and full rises, which
// holds off further input until an entry drains.
// rst (synchronous, active high) clears the parser and empties the queue.
module websocket_frame_deframer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] event_kind,
  output logic [7:0] payload_byte,
  output logic [3:0] frame_opcode,
  output logic       frame_end,
  output logic       message_end
);

  logic              q_full;
  logic              q_push;
  wfd_pkg::wfd_rec_t q_rec;
  wfd_pkg::wfd_rec_t head;

  wfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req_type (req_type),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (q_rec)
  );

  wfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_rec (q_rec),
    .full   (q_full),
    .pop    (pop),
    .empty  (empty),
    .head   (head)
  );

  wfd_back u_back (
    .rec          (head),
    .event_kind   (event_kind),
    .payload_byte (payload_byte),
    .frame_opcode (frame_opcode),
    .frame_end    (frame_end),
    .message_end  (message_end)
  );

endmodule

// ===== tb/sv/websocket_frame_deframer_unit_tb.sv =====
// testbench for websocket_frame_deframer_unit: frame streams checked against a built-in parser
`timescale 1ns / 1ps

module websocket_frame_deframer_unit_tb;

  localparam int RANDOM_ITEMS_TARGET = 1850;
  localparam int RX_STALL_CYCLES     = 300;
  localparam int IDLE_LIMIT          = 2000;

  // opcodes without a name in the package
  localparam logic [3:0] OP_CONT      = 4'd0;
  localparam logic [3:0] OP_TEXT      = 4'd1;
  localparam logic [3:0] OP_BINARY    = 4'd2;
  localparam logic [3:0] OP_BAD_FIRST = 4'd3;
  localparam logic [3:0] OP_BAD_LAST  = 4'd15;

  typedef enum logic [2:0] {
    PS_HDR0, PS_HDR1, PS_EXTLEN, PS_KEY, PS_PAYLOAD
  } parse_state_t;

  typedef enum logic [2:0] {
    FC_DATA, FC_PING, FC_PONG, FC_CLOSE, FC_BAD
  } frame_class_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       frame_end;
    logic       msg_end;
  } frame_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       req_type = wfd_pkg::REQ_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [2:0] event_kind;
  logic [7:0] payload_byte;
  logic [3:0] frame_opcode;
  logic       frame_end;
  logic       message_end;

  // parser copy kept in step with the dut
  parse_state_t parse_state;
  logic         cur_fin;
  logic [3:0]   cur_opcode;
  logic         cur_masked;
  logic [3:0]   ext_left;
  logic [63:0]  remaining;
  logic [31:0]  mask_key;
  logic [1:0]   key_idx;

  frame_event_t pending_events[$];
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           stall_requests = 0;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;

  websocket_frame_deframer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .event_kind   (event_kind),
    .payload_byte (payload_byte),
    .frame_opcode (frame_opcode),
    .frame_end    (frame_end),
    .message_end  (message_end)
  );

  always #6 clk = ~clk;

  function automatic void clear_parser();
    parse_state = PS_HDR0;
    cur_fin     = 1'b0;
    cur_opcode  = 4'd0;
    cur_masked  = 1'b0;
    ext_left    = 4'd0;
    remaining   = 64'd0;
    mask_key    = 32'd0;
    key_idx     = 2'd0;
  endfunction

  function automatic frame_class_t classify(input logic [3:0] op);
    if (op <= wfd_pkg::OP_DATA_MAX) return FC_DATA;
    if (op == wfd_pkg::OP_PING) return FC_PING;
    if (op == wfd_pkg::OP_PONG) return FC_PONG;
    if (op == wfd_pkg::OP_CLOSE) return FC_CLOSE;
    return FC_BAD;
  endfunction

  function automatic void queue_event(input logic [2:0] kind, input logic [7:0] data,
                                      input logic last);
    frame_event_t ev;
    ev.kind      = kind;
    ev.data      = data;
    ev.opcode    = cur_opcode;
    ev.frame_end = last;
    ev.msg_end   = last & cur_fin;
    pending_events.push_back(ev);
  endfunction

  // single event that closes a frame; empty pong gives nothing
  function automatic void close_frame();
    case (classify(cur_opcode))
      FC_DATA:  queue_event(wfd_pkg::EV_EMPTY_DATA, 8'h00, 1'b1);
      FC_PING:  queue_event(wfd_pkg::EV_EMPTY_PING, 8'h00, 1'b1);
      FC_CLOSE: queue_event(wfd_pkg::EV_CLOSE, 8'h00, 1'b1);
      FC_BAD:   queue_event(wfd_pkg::EV_BAD_OP, 8'h00, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic void header_complete();
    key_idx = 2'd0;
    if (remaining == 64'd0) begin
      parse_state = PS_HDR0;
      close_frame();
    end else begin
      parse_state = PS_PAYLOAD;
    end
  endfunction

  function automatic void length_known();
    if (cur_masked) begin
      parse_state = PS_KEY;
      key_idx = 2'd0;
    end else begin
      header_complete();
    end
  endfunction

  function automatic void advance_parser(input logic req, input logic [7:0] b);
    logic [6:0] len7;
    logic [7:0] kb;
    logic [7:0] data;
    logic       last;
    if (req == wfd_pkg::REQ_LINK_RESET) begin
      clear_parser();
      return;
    end
    case (parse_state)
      PS_HDR1: begin
        cur_masked = b[7];
        len7 = b[6:0];
        mask_key = 32'd0;
        key_idx = 2'd0;
        remaining = 64'd0;
        if (len7 == wfd_pkg::LEN_EXT16) begin
          ext_left = wfd_pkg::EXT16_BYTES;
          parse_state = PS_EXTLEN;
        end else if (len7 == wfd_pkg::LEN_EXT64) begin
          ext_left = wfd_pkg::EXT64_BYTES;
          parse_state = PS_EXTLEN;
        end else begin
          remaining = 64'(len7);
          length_known();
        end
      end
      PS_EXTLEN: begin
        remaining = {remaining[55:0], b};
        if (ext_left != 4'd0) ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) length_known();
      end
      PS_KEY: begin
        mask_key = {mask_key[23:0], b};
        key_idx = key_idx + 2'd1;
        if (key_idx == 2'd0) header_complete();
      end
      PS_PAYLOAD: begin
        // first key byte sits in the top byte
        kb = 8'(mask_key >> (24 - 8 * key_idx));
        data = b ^ kb;
        key_idx = key_idx + 2'd1;
        if (remaining != 64'd0) remaining = remaining - 64'd1;
        last = (remaining == 64'd0);
        if (last) parse_state = PS_HDR0;
        case (classify(cur_opcode))
          FC_DATA: queue_event(wfd_pkg::EV_DATA, data, last);
          FC_PING: queue_event(wfd_pkg::EV_PING, data, last);
          FC_PONG: ;
          default: if (last) close_frame();
        endcase
      end
      default: begin
        cur_fin = b[7];
        cur_opcode = b[3:0];
        ext_left = 4'd0;
        parse_state = PS_HDR1;
      end
    endcase
  endfunction

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [3:0] pick_opcode();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 50) return 4'($urandom_range(OP_CONT, OP_BINARY));
    if (r < 65) return wfd_pkg::OP_PING;
    if (r < 75) return wfd_pkg::OP_PONG;
    if (r < 85) return wfd_pkg::OP_CLOSE;
    // reserved opcodes 3..7 and 11..15
    v = $urandom_range(OP_BAD_FIRST, 12);
    if (v > 7) v = v + 3;
    return 4'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result();
    frame_event_t want;
    if (pending_events.size() == 0) begin
      report_mismatch("result with none expected");
      return;
    end
    want = pending_events.pop_front();
    check_field("event_kind", 8'(event_kind), 8'(want.kind));
    check_field("payload_byte", payload_byte, want.data);
    check_field("frame_opcode", 8'(frame_opcode), 8'(want.opcode));
    check_field("frame_end", 8'(frame_end), 8'(want.frame_end));
    check_field("message_end", 8'(message_end), 8'(want.msg_end));
  endtask

  // one input transfer; push stays high if the next item follows with no gap
  task automatic send_item(input logic req, input logic [7:0] b);
    int gap;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    req_type <= req;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    advance_parser(req, b);
    items_sent++;
  endtask

  // sends a whole frame, or its first cut bytes followed by a link reset
  task automatic send_frame(input logic [7:0] hdr0, input logic masked, input logic [6:0] len_field,
                            input logic [63:0] length, input logic [31:0] key, input int cut);
    logic [7:0]      header[$];
    longint unsigned total;
    longint unsigned n_stop;
    longint unsigned n;
    int              i;
    header.push_back(hdr0);
    header.push_back({masked, len_field});
    if (len_field == wfd_pkg::LEN_EXT16) begin
      for (i = 1; i >= 0; i--) header.push_back(length[8*i +: 8]);
    end else if (len_field == wfd_pkg::LEN_EXT64) begin
      for (i = 7; i >= 0; i--) header.push_back(length[8*i +: 8]);
    end
    if (masked) begin
      for (i = 3; i >= 0; i--) header.push_back(key[8*i +: 8]);
    end
    total = length + header.size();
    n_stop = (cut >= 0 && cut < total) ? longint'(cut) : total;
    for (n = 0; n < n_stop; n++) begin
      send_item(wfd_pkg::REQ_BYTE, (n < header.size()) ? header[n] : 8'($urandom));
    end
    if (n_stop < total) send_item(wfd_pkg::REQ_LINK_RESET, 8'($urandom));
  endtask

  task automatic test_directed_frames();
    logic [7:0] seq[$];
    seq = {
      // binary, final, one byte
      {1'b1, 3'b000, OP_BINARY}, 8'h01, 8'hFF,
      // empty continuation without fin
      {1'b0, 3'b000, OP_CONT}, 8'h00,
      {1'b1, 3'b000, wfd_pkg::OP_PING}, 8'h00,
      // empty pong gives nothing
      {1'b1, 3'b000, wfd_pkg::OP_PONG}, 8'h00,
      {1'b1, 3'b000, wfd_pkg::OP_CLOSE}, 8'h00,
      // reserved opcode with rsv bits set, payload swallowed
      {1'b0, 3'b111, OP_BAD_LAST}, 8'h01, 8'h00,
      // masked empty text, event comes with the last key byte
      {1'b1, 3'b000, OP_TEXT}, 8'h80, 8'hA5, 8'h5A, 8'h00, 8'hFF,
      {1'b1, 3'b000, OP_BAD_FIRST}
    };
    foreach (seq[k]) send_item(wfd_pkg::REQ_BYTE, seq[k]);
    send_item(wfd_pkg::REQ_LINK_RESET, 8'hFF);
  endtask

  // receiver stops for a long stretch while frames keep coming
  task automatic test_fill_and_stall();
    tx_idle_on = 1'b0;
    stall_requests++;
    repeat (3) send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, 7'd8, 64'd8, $urandom, -1);
    send_frame({1'b1, 3'b000, wfd_pkg::OP_PING}, 1'b0, 7'd5, 64'd5, 32'd0, -1);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          frames;
    int          r;
    logic [7:0]  hdr0;
    logic        masked;
    logic [6:0]  len_field;
    logic [63:0] length;
    int          cut;
    frames = 0;
    while (items_sent < RANDOM_ITEMS_TARGET) begin
      if (frames % 40 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on <= ($urandom_range(0, 3) != 0);
      end
      frames++;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        // line noise, then resync
        repeat ($urandom_range(1, 6)) send_item(wfd_pkg::REQ_BYTE, 8'($urandom));
        send_item(wfd_pkg::REQ_LINK_RESET, 8'($urandom));
      end else begin
        hdr0 = {1'($urandom), 3'($urandom), pick_opcode()};
        masked = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10) begin
          length = 64'd0;
        end else if (r < 72) begin
          length = 64'($urandom_range(1, 8));
        end else if (r < 76) begin
          length = 64'($urandom_range(9, 125));
        end else if (r < 92) begin
          length = ($urandom_range(0, 29) == 0) ? 64'($urandom_range(126, 300))
                                                : 64'($urandom_range(0, 40));
        end else begin
          length = 64'($urandom_range(0, 20));
        end
        if (r < 76) len_field = length[6:0];
        else if (r < 92) len_field = wfd_pkg::LEN_EXT16;
        else len_field = wfd_pkg::LEN_EXT64;
        cut = -1;
        r = $urandom_range(0, 99);
        if (r < 8) begin
          cut = $urandom_range(1, 12);
        end else if (r == 8) begin
          // top bit of the 64-bit length set: frame never ends on its own
          len_field = wfd_pkg::LEN_EXT64;
          length = {2'b10, 30'($urandom), 32'($urandom)};
          cut = $urandom_range(10, 24);
        end
        send_frame(hdr0, masked, len_field, length, $urandom, cut);
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    int stalls_served;
    gap = 0;
    stalls_served = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (pop && !empty) begin
          check_result();
          gap = pick_gap(rx_idle_on);
        end
        if (stalls_served != stall_requests) begin
          stalls_served++;
          gap = RX_STALL_CYCLES;
        end
        if (gap > 0) begin
          pop <= 1'b0;
          gap--;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("websocket_frame_deframer_unit test failed");
    $finish;
  end

  initial begin
    clear_parser();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_fill_and_stall();
    test_random_traffic();
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    // let any stray result reach the result sink before the verdict
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("websocket_frame_deframer_unit test passed");
    end else begin
      $display("websocket_frame_deframer_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/wfd_pkg.sv
design/wfd_front.sv
design/wfd_queue.sv
design/wfd_back.sv
design/websocket_frame_deframer_unit.sv
tb/sv/websocket_frame_deframer_unit_tb.sv
